### sv/abr_pkg.sv
// shared types, constants and the reciprocal table of the alpha box blur
package abr_pkg;

  localparam int MAX_RADIUS = 15;
  localparam int RAD_W = 4;
  localparam int CELLS = 2 * MAX_RADIUS + 1;
  localparam int IDX_W = $clog2(CELLS);
  localparam int SEEN_W = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam int PIX_W = 8;
  localparam int SUM_W = 13;
  localparam int RECIP_W = 19;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef struct packed {
    logic [PIX_W-1:0] alpha_in;
    logic             row_end;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] alpha_out;
    logic             row_last;
  } out_t;

  // one output position travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] hi;
    logic [RAD_W-1:0] r;
    logic             last;
  } token_t;

  // ceil(2^18 / (2r+1)); exact floor division for any 13-bit sum
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd0:    m = 19'd262144;
      4'd1:    m = 19'd87382;
      4'd2:    m = 19'd52429;
      4'd3:    m = 19'd37450;
      4'd4:    m = 19'd29128;
      4'd5:    m = 19'd23832;
      4'd6:    m = 19'd20165;
      4'd7:    m = 19'd17477;
      4'd8:    m = 19'd15421;
      4'd9:    m = 19'd13798;
      4'd10:   m = 19'd12484;
      4'd11:   m = 19'd11398;
      4'd12:   m = 19'd10486;
      4'd13:   m = 19'd9710;
      4'd14:   m = 19'd9040;
      4'd15:   m = 19'd8457;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

endpackage

### sv/abr_cell.sv
// one cell of the chain: holds one pixel and adds it to a passing window sum
module abr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      shift,
  input  logic [abr_pkg::IDX_W-1:0] idx,
  input  logic [abr_pkg::PIX_W-1:0] pix_in,
  output logic [abr_pkg::PIX_W-1:0] pix,
  input  abr_pkg::token_t           tok_in,
  output abr_pkg::token_t           tok
);

  abr_pkg::token_t tok_next;

  always_comb begin
    tok_next = tok_in;
    // cell idx sits idx pixels behind the newest one
    if (tok_in.valid && (idx <= tok_in.hi)) begin
      tok_next.sum = tok_in.sum + abr_pkg::SUM_W'(pix);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      pix <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (adv) begin
      tok <= tok_next;
    end
  end

endmodule

### sv/abr_seq.sv
// row bookkeeping, radius register and launch of window tokens into the chain
module abr_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [abr_pkg::RAD_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  abr_pkg::in_t              in_item,
  output logic                      in_ready,
  input  logic                      adv,
  input  logic                      busy,
  output abr_pkg::token_t           tok
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LAUNCH = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [abr_pkg::RAD_W-1:0]  radius;
  logic [abr_pkg::RAD_W-1:0]  r_q;
  logic [abr_pkg::RAD_W-1:0]  d;
  logic [abr_pkg::SEEN_W-1:0] pixels_seen;
  logic [abr_pkg::SEEN_W-1:0] last_q;
  logic                       end_q;
  logic [abr_pkg::PIX_W-1:0]  newest;
  logic [abr_pkg::PIX_W-1:0]  first_pixel;

  logic                       accept;
  logic [abr_pkg::RAD_W-1:0]  r_eff;
  logic                       last_ge_r;
  logic                       has_tok;
  logic [abr_pkg::RAD_W-1:0]  d_start;
  logic [abr_pkg::IDX_W-1:0]  reach;
  logic                       past_edge;
  logic [abr_pkg::IDX_W-1:0]  cnt_first;
  logic [abr_pkg::RAD_W-1:0]  cnt_new;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign r_eff = (radius > abr_pkg::RAD_W'(abr_pkg::MAX_RADIUS)) ?
                 abr_pkg::RAD_W'(abr_pkg::MAX_RADIUS) : radius;
  assign last_ge_r = pixels_seen >= abr_pkg::SEEN_W'(r_eff);
  assign has_tok   = in_item.row_end || last_ge_r;
  // window centres counted back from the newest pixel, oldest first
  assign d_start   = (in_item.row_end && !last_ge_r) ?
                     pixels_seen[abr_pkg::RAD_W-1:0] : r_eff;

  // left (oldest) edge of the window relative to the newest pixel, and the part
  // of it that falls left of the row start
  assign reach     = abr_pkg::IDX_W'(r_q) + abr_pkg::IDX_W'(d);
  assign past_edge = abr_pkg::SEEN_W'(reach) > last_q;
  assign cnt_first = past_edge ? abr_pkg::IDX_W'(abr_pkg::SEEN_W'(reach) - last_q) : '0;
  assign cnt_new   = r_q - d;

  always_comb begin
    tok       = '0;
    tok.valid = (state == ST_LAUNCH);
    tok.hi    = past_edge ? last_q[abr_pkg::IDX_W-1:0] : reach;
    tok.r     = r_q;
    tok.last  = end_q && (d == '0);
    tok.sum   = abr_pkg::SUM_W'(cnt_new) * abr_pkg::SUM_W'(newest)
              + abr_pkg::SUM_W'(cnt_first) * abr_pkg::SUM_W'(first_pixel);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && has_tok) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (adv && ((d == '0) || !end_q)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      radius      <= '0;
      pixels_seen <= '0;
      first_pixel <= '0;
      r_q         <= '0;
      d           <= '0;
      last_q      <= '0;
      end_q       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      if (accept) begin
        newest <= in_item.alpha_in;
        r_q    <= r_eff;
        last_q <= pixels_seen;
        end_q  <= in_item.row_end;
        d      <= d_start;
        if (pixels_seen == '0) begin
          first_pixel <= in_item.alpha_in;
        end
        if (in_item.row_end) begin
          pixels_seen <= '0;
        end else if (pixels_seen != abr_pkg::SEEN_MAX) begin
          pixels_seen <= pixels_seen + 1'b1;
        end
      end else if ((state == ST_LAUNCH) && adv && (d != '0)) begin
        d <= d - 1'b1;
      end
    end
  end

endmodule

### sv/abr_recip.sv
// division by the window length as a reciprocal multiply, then the output register
module abr_recip (
  input  logic            clk,
  input  logic            rst,
  input  abr_pkg::token_t tok,
  output logic            adv,
  output logic            m_valid,
  output logic            out_valid,
  input  logic            out_ready,
  output abr_pkg::out_t   out_item
);

  logic [abr_pkg::PROD_W-1:0] m_prod;
  logic                       m_last;

  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= tok.valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod            <= abr_pkg::PROD_W'(tok.sum) * abr_pkg::PROD_W'(abr_pkg::recip(tok.r));
      m_last            <= tok.last;
      out_item.alpha_out <= m_prod[abr_pkg::RECIP_SHIFT +: abr_pkg::PIX_W];
      out_item.row_last  <= m_last;
    end
  end

endmodule

### sv/alpha_box_blur_row.sv
// top level of the horizontal alpha box blur with clamp to edge
//
//   port group            dir  handshake          item
//   in_item               in   in_valid/in_ready  one pixel, row end flag
//   out_item              out  out_valid/out_ready one averaged pixel, row last flag
//   cfg_wdata             in   cfg_we             radius, no wait
//
// an item giving n results (0, 1, or up to 16 on a row end) passes through
// n launches, the 31 cells of the adder chain, the reciprocal multiply and
// the return to idle before a new item is taken; an item giving no result
// leaves the block idle. reset (rst, synchronous) empties the chain and
// clears the row count and radius. a stalled output freezes the whole chain.
module alpha_box_blur_row (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [abr_pkg::RAD_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  abr_pkg::in_t              in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output abr_pkg::out_t             out_item
);

  abr_pkg::token_t           tok_link [abr_pkg::CELLS+1];
  logic [abr_pkg::PIX_W-1:0] pix_link [abr_pkg::CELLS+1];

  logic adv;
  logic m_valid;
  logic chain_busy;
  logic busy;
  logic shift;

  assign shift       = in_valid && in_ready;
  assign pix_link[0] = in_item.alpha_in;

  abr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .adv       (adv),
    .busy      (busy),
    .tok       (tok_link[0])
  );

  for (genvar j = 0; j < abr_pkg::CELLS; j++) begin : g_cell
    abr_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .shift  (shift),
      .idx    (abr_pkg::IDX_W'(j)),
      .pix_in (pix_link[j]),
      .pix    (pix_link[j+1]),
      .tok_in (tok_link[j]),
      .tok    (tok_link[j+1])
    );
  end

  always_comb begin
    chain_busy = 1'b0;
    for (int j = 1; j <= abr_pkg::CELLS; j++) begin
      chain_busy = chain_busy | tok_link[j].valid;
    end
  end

  assign busy = chain_busy || m_valid;

  abr_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_link[abr_pkg::CELLS]),
    .adv       (adv),
    .m_valid   (m_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
